@@ hw/rtl/u2u8_pkg.sv @@
package u2u8_pkg;

    localparam int MAX_LIMIT = 65536;

    localparam int UNIT_W  = 16;
    localparam int LEN_W   = 17;
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int NEED_W  = 3;
    localparam int MAX_RES = 4;

    localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(65536);
    localparam logic [LEN_W-1:0] LIMIT_CAP   = LEN_W'(MAX_LIMIT);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    // results caused by one accepted code unit
    typedef struct packed {
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
        logic [NEED_W-1:0]              n_res;
        logic                           has_bytes;
        logic                           eos;
        t_status                        status;
        logic [LEN_W-1:0]               total;
    } t_burst;

endpackage

@@ hw/rtl/u2u8_in_if.sv @@
interface u2u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_string;

    modport source (output valid, output code_unit, output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

@@ hw/rtl/u2u8_out_if.sv @@
interface u2u8_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        string_done;
    logic [1:0]  status;
    logic [16:0] total_length;

    modport source (
        output valid, output out_byte, output byte_valid, output run_last,
        output string_done, output status, output total_length, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input run_last,
        input string_done, input status, input total_length, output ready
    );
endinterface

@@ hw/rtl/u2u8_decode.sv @@
module u2u8_decode (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [u2u8_pkg::LEN_W-1:0]          i_cfg_wdata,
    input  logic                                i_accept,
    input  logic [u2u8_pkg::UNIT_W-1:0]         i_code_unit,
    input  logic                                i_end_of_string,
    output u2u8_pkg::t_burst                    o_burst
);

    logic [u2u8_pkg::LEN_W-1:0]  r_byte_limit;
    logic                        r_high_pending;
    logic [9:0]                  r_high_bits;
    logic [u2u8_pkg::LEN_W-1:0]  r_bytes_used;
    u2u8_pkg::t_status           r_error_status;

    logic                        n_high_pending;
    logic [9:0]                  n_high_bits;
    logic [u2u8_pkg::LEN_W-1:0]  n_bytes_used;
    u2u8_pkg::t_status           n_error_status;

    logic                        is_high;
    logic                        is_low;
    logic                        have_cp;
    u2u8_pkg::t_status           dec_status;
    logic [u2u8_pkg::CP_W-1:0]   cp;
    logic [u2u8_pkg::NEED_W-1:0] need;
    logic [u2u8_pkg::LEN_W-1:0]  lim;
    logic [u2u8_pkg::LEN_W:0]    sum;
    logic                        over;
    logic                        emit;
    logic [3:0][7:0]             enc;

    assign is_high = (i_code_unit[15:10] == 6'b110110);
    assign is_low  = (i_code_unit[15:10] == 6'b110111);

    always_comb begin
        n_high_pending = r_high_pending;
        n_high_bits    = r_high_bits;
        dec_status     = r_error_status;
        have_cp        = 1'b0;
        cp             = {5'd0, i_code_unit};
        if (r_error_status == u2u8_pkg::ST_OK) begin
            if (r_high_pending) begin
                n_high_pending = 1'b0;
                n_high_bits    = 10'd0;
                // supplementary point: ((high + 0x40) << 10) | low
                cp = {11'({1'b0, r_high_bits} + 11'd64), i_code_unit[9:0]};
                if (is_low) begin
                    have_cp = 1'b1;
                end else begin
                    dec_status = u2u8_pkg::ST_INVALID;
                end
            end else if (is_high) begin
                if (i_end_of_string) begin
                    dec_status = u2u8_pkg::ST_INVALID;
                end else begin
                    n_high_pending = 1'b1;
                    n_high_bits    = i_code_unit[9:0];
                end
            end else if (i_code_unit == 16'd0 || is_low) begin
                dec_status = u2u8_pkg::ST_INVALID;
            end else begin
                have_cp = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (cp < 21'h80) begin
            need = 3'd1;
        end else if (cp < 21'h800) begin
            need = 3'd2;
        end else if (cp < 21'h10000) begin
            need = 3'd3;
        end else begin
            need = 3'd4;
        end
    end

    assign lim  = (r_byte_limit < u2u8_pkg::LIMIT_CAP) ? r_byte_limit : u2u8_pkg::LIMIT_CAP;
    assign sum  = {1'b0, r_bytes_used} + {15'd0, need};
    assign over = (sum > {1'b0, lim});
    assign emit = have_cp && !over;

    always_comb begin
        enc = '0;
        unique case (need)
            3'd1: enc[0] = cp[7:0];
            3'd2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3'd3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
    end

    always_comb begin
        n_bytes_used   = r_bytes_used;
        n_error_status = dec_status;
        if (have_cp && over) begin
            n_error_status = u2u8_pkg::ST_OVERFLOW;
        end
        if (emit) begin
            n_bytes_used = sum[u2u8_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        o_burst.bytes     = enc;
        o_burst.has_bytes = emit;
        o_burst.eos       = i_end_of_string;
        o_burst.status    = emit ? u2u8_pkg::ST_OK : n_error_status;
        if (emit) begin
            o_burst.n_res = need;
        end else begin
            o_burst.n_res = {2'd0, i_end_of_string};
        end
        // an error closes the string with a zero length
        if (emit || n_error_status == u2u8_pkg::ST_OK) begin
            o_burst.total = n_bytes_used;
        end else begin
            o_burst.total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit   <= u2u8_pkg::LIMIT_RESET;
            r_high_pending <= 1'b0;
            r_high_bits    <= 10'd0;
            r_bytes_used   <= '0;
            r_error_status <= u2u8_pkg::ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_byte_limit <= i_cfg_wdata;
            end
            if (i_accept) begin
                if (i_end_of_string) begin
                    r_high_pending <= 1'b0;
                    r_high_bits    <= 10'd0;
                    r_bytes_used   <= '0;
                    r_error_status <= u2u8_pkg::ST_OK;
                end else begin
                    r_high_pending <= n_high_pending;
                    r_high_bits    <= n_high_bits;
                    r_bytes_used   <= n_bytes_used;
                    r_error_status <= n_error_status;
                end
            end
        end
    end

    a_no_pending_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error_status != u2u8_pkg::ST_OK) |-> !r_high_pending)
        else $error("high surrogate held while string is in error");

    a_used_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_used <= u2u8_pkg::LIMIT_CAP)
        else $error("byte count past the limit cap");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_string) |=> (r_bytes_used == '0 && !r_high_pending))
        else $error("string state not cleared at end of string");

endmodule

@@ hw/rtl/u2u8_emit.sv @@
module u2u8_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u2u8_pkg::t_burst  i_burst,
    output logic              o_free,
    u2u8_out_if.source        o_out
);

    u2u8_pkg::t_burst r_burst;
    logic             r_busy;
    logic [1:0]       r_idx;

    logic             is_last;
    logic             take;
    logic             done;

    assign is_last = ({1'b0, r_idx} == (r_burst.n_res - 3'd1));
    assign take    = r_busy && o_out.ready;
    assign done    = is_last && r_burst.eos;
    // next request may enter as the final byte of the current one leaves
    assign o_free  = !r_busy || (take && is_last);

    assign o_out.valid        = r_busy;
    assign o_out.out_byte     = r_burst.has_bytes ? r_burst.bytes[r_idx] : 8'd0;
    assign o_out.byte_valid   = r_burst.has_bytes;
    assign o_out.run_last     = is_last;
    assign o_out.string_done  = done;
    assign o_out.status       = done ? r_burst.status : u2u8_pkg::ST_OK;
    assign o_out.total_length = done ? r_burst.total : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= 2'd0;
            r_burst <= '0;
        end else begin
            if (i_load && i_burst.n_res != 3'd0) begin
                r_busy  <= 1'b1;
                r_idx   <= 2'd0;
                r_burst <= i_burst;
            end else if (take) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < r_burst.n_res))
        else $error("byte index past burst length");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_busy) |-> (take && is_last))
        else $error("request loaded over a burst still in flight");

    a_idx_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_out.ready) |=> $stable(r_idx))
        else $error("byte index moved while output stalled");

endmodule

@@ hw/rtl/utf16_to_utf8_transcoder_core.sv @@
// UTF-16 to UTF-8 transcoder. Each request carries one code unit; it yields up
// to four UTF-8 bytes on the output channel, one result per cycle from an output
// register while the receiver is ready, and the input waits until every result
// of the previous request has left the output register. Decoding, the byte
// limit check and encoding happen in the cycle the unit is taken; the next unit
// is taken in the same cycle the last byte of the previous one leaves. A high
// surrogate is held until the next unit; NUL, a lone low surrogate, or a high
// surrogate that is unpaired or ends the string flags invalid, and exceeding
// byte_limit flags overflow; after an error the rest of the string is dropped.
// The unit marked end_of_string closes the string with status and total length.
// Write byte_limit only while no request is in flight.
module utf16_to_utf8_transcoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [u2u8_pkg::LEN_W-1:0]  i_cfg_wdata,
    u2u8_in_if.sink                     i_in,
    u2u8_out_if.source                  o_out
);

    u2u8_pkg::t_burst burst;
    logic             free;
    logic             accept;

    assign i_in.ready = free;
    assign accept     = i_in.valid && free;

    u2u8_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_code_unit     (i_in.code_unit),
        .i_end_of_string (i_in.end_of_string),
        .o_burst         (burst)
    );

    u2u8_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_burst (burst),
        .o_free  (free),
        .o_out   (o_out)
    );

endmodule

@@ bench/u2u8_checker.sv @@
module u2u8_checker
    import u2u8_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    u2u8_in_if               i_in,
    u2u8_out_if              i_out,
    output int               o_fail_count,
    output int               o_pending_count
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              string_done;
        t_status           status;
        logic [LEN_W-1:0]  total_length;
    } utf8_result_t;

    utf8_result_t utf8_expect_q[$];

    logic [LEN_W-1:0] byte_limit;
    logic             high_pending;
    logic [9:0]       high_bits;
    logic [LEN_W-1:0] bytes_used;
    t_status          err_status;
    int               fail_total;

    task automatic push_result(input logic [7:0] b, input logic bv, input logic last,
                               input logic done, input t_status st,
                               input logic [LEN_W-1:0] len);
        utf8_result_t r;
        r.out_byte     = b;
        r.byte_valid   = bv;
        r.run_last     = last;
        r.string_done  = done;
        r.status       = st;
        r.total_length = len;
        utf8_expect_q.push_back(r);
    endtask

    // decode one code unit, check the limit and queue the results it yields
    task automatic encode_unit(input logic [15:0] unit, input logic eos);
        logic [20:0]      cp;
        logic             have_cp;
        logic [7:0]       seq [4];
        int               n;
        int               need;
        logic [LEN_W-1:0] lim;
        logic [LEN_W-1:0] room;
        logic             last;
        cp      = '0;
        have_cp = 1'b0;
        n       = 0;
        if (err_status == ST_OK) begin
            if (high_pending) begin
                high_pending = 1'b0;
                if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
                    cp      = 21'h10000 + {high_bits, unit[9:0]};
                    have_cp = 1'b1;
                end else begin
                    err_status = ST_INVALID;
                end
                high_bits = '0;
            end else if (unit >= 16'hd800 && unit <= 16'hdbff) begin
                if (eos) begin
                    err_status = ST_INVALID;
                end else begin
                    high_pending = 1'b1;
                    high_bits    = unit[9:0];
                end
            end else if (unit == 16'h0000 || (unit >= 16'hdc00 && unit <= 16'hdfff)) begin
                err_status = ST_INVALID;
            end else begin
                cp      = {5'd0, unit};
                have_cp = 1'b1;
            end
        end

        if (have_cp) begin
            lim  = (byte_limit < LIMIT_CAP) ? byte_limit : LIMIT_CAP;
            need = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            room = (lim > bytes_used) ? lim - bytes_used : '0;
            if (need > room) begin
                err_status = ST_OVERFLOW;
            end else begin
                case (need)
                    1: begin
                        seq[0] = cp[7:0];
                    end
                    2: begin
                        seq[0] = {3'b110, cp[10:6]};
                        seq[1] = {2'b10, cp[5:0]};
                    end
                    3: begin
                        seq[0] = {4'b1110, cp[15:12]};
                        seq[1] = {2'b10, cp[11:6]};
                        seq[2] = {2'b10, cp[5:0]};
                    end
                    default: begin
                        seq[0] = {5'b11110, cp[20:18]};
                        seq[1] = {2'b10, cp[17:12]};
                        seq[2] = {2'b10, cp[11:6]};
                        seq[3] = {2'b10, cp[5:0]};
                    end
                endcase
                n          = need;
                bytes_used = bytes_used + LEN_W'(need);
            end
        end

        for (int i = 0; i < n; i++) begin
            last = (i == n - 1);
            push_result(seq[i], 1'b1, last, last && eos, ST_OK,
                        (last && eos) ? bytes_used : '0);
        end

        if (eos) begin
            // string closes without a byte of its own
            if (n == 0)
                push_result(8'h00, 1'b0, 1'b1, 1'b1, err_status,
                            (err_status == ST_OK) ? bytes_used : '0);
            high_pending = 1'b0;
            high_bits    = '0;
            bytes_used   = '0;
            err_status   = ST_OK;
        end
    endtask

    always @(posedge i_clk) begin
        utf8_result_t want;
        if (!i_rst_n) begin
            byte_limit   = LIMIT_RESET;
            high_pending = 1'b0;
            high_bits    = '0;
            bytes_used   = '0;
            err_status   = ST_OK;
            utf8_expect_q.delete();
        end else begin
            if (i_cfg_we)
                byte_limit = i_cfg_wdata;
            if (i_in.valid && i_in.ready)
                encode_unit(i_in.code_unit, i_in.end_of_string);
            if (i_out.valid && i_out.ready) begin
                if (utf8_expect_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected %02h bv %0d last %0d done %0d st %0d len %0d",
                                 i_out.out_byte, i_out.byte_valid, i_out.run_last,
                                 i_out.string_done, i_out.status, i_out.total_length);
                end else begin
                    want = utf8_expect_q.pop_front();
                    if (want.out_byte !== i_out.out_byte
                            || want.byte_valid !== i_out.byte_valid
                            || want.run_last !== i_out.run_last
                            || want.string_done !== i_out.string_done
                            || want.status !== i_out.status
                            || want.total_length !== i_out.total_length) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("exp %02h bv %0d last %0d done %0d st %0d len %0d",
                                     want.out_byte, want.byte_valid, want.run_last,
                                     want.string_done, want.status, want.total_length);
                            $display("got %02h bv %0d last %0d done %0d st %0d len %0d",
                                     i_out.out_byte, i_out.byte_valid, i_out.run_last,
                                     i_out.string_done, i_out.status, i_out.total_length);
                        end
                    end
                end
            end
        end
        o_fail_count    <= fail_total;
        o_pending_count <= utf8_expect_q.size();
    end

    initial begin
        fail_total      = 0;
        o_fail_count    = 0;
        o_pending_count = 0;
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import u2u8_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_UNITS = 46;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending_count;
    int               units_sent;
    int               cycles;
    bit               quiet;
    bit               hold_req;

    u2u8_in_if  in_ch ();
    u2u8_out_if out_ch ();

    utf16_to_utf8_transcoder_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    u2u8_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // byte receiver: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req     = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_ch.ready = quiet || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    task automatic send_unit(input logic [15:0] unit, input logic eos);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.code_unit     = unit;
        in_ch.end_of_string = eos;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        units_sent++;
    endtask

    // let every expected byte come out before touching the register
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // three-byte bmp value, surrogate range skipped
    function automatic logic [15:0] pick_bmp3();
        logic [15:0] v;
        v = 16'($urandom_range(16'h0800, 16'hf7ff));
        if (v >= 16'hd800)
            v = v + 16'h0800;
        return v;
    endfunction

    task automatic send_pair(input logic [20:0] cp, input logic eos);
        logic [19:0] off;
        off = 20'(cp - 21'h10000);
        send_unit({6'b110110, off[19:10]}, 1'b0);
        send_unit({6'b110111, off[9:0]}, eos);
    endtask

    task automatic send_point(input logic is_last);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            send_unit(16'($urandom_range(1, 16'h7f)), is_last);
        else if (sel < 45)
            send_unit(16'($urandom_range(16'h80, 16'h7ff)), is_last);
        else if (sel < 75)
            send_unit(pick_bmp3(), is_last);
        else
            send_pair(21'($urandom_range(21'h10000, 21'h10ffff)), is_last);
    endtask

    task automatic send_random_string();
        int count;
        int sel;
        logic [15:0] unit;
        if ($urandom_range(0, 99) < 82) begin
            count = $urandom_range(1, 8);
            for (int k = 0; k < count; k++)
                send_point(k == count - 1);
        end else begin
            // noise: stray surrogates, nul and arbitrary units
            count = $urandom_range(1, 6);
            for (int k = 0; k < count; k++) begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0:       unit = 16'($urandom_range(0, 16'hffff));
                    1:       unit = 16'h0000;
                    2:       unit = 16'($urandom_range(16'hdc00, 16'hdfff));
                    3:       unit = 16'($urandom_range(16'hd800, 16'hdbff));
                    default: unit = pick_bmp3();
                endcase
                send_unit(unit, k == count - 1);
            end
        end
    endtask

    initial begin
        int target;
        logic [LEN_W-1:0] lim;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.code_unit     = '0;
        in_ch.end_of_string = 1'b0;
        quiet               = 1'b0;
        hold_req            = 1'b0;
        units_sent          = 0;
        cycles              = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // every encoding width and its boundaries, at the reset limit
        send_unit(16'h0041, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hffff, 1'b0);
        send_pair(21'h10000, 1'b0);
        send_pair(21'h10ffff, 1'b1);
        // nul, lone low surrogate with the rest dropped
        send_unit(16'h0000, 1'b1);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'h0041, 1'b1);
        // high surrogate followed by a non-low unit, and high at the end
        send_unit(16'hd800, 1'b0);
        send_unit(16'h0042, 1'b1);
        send_unit(16'hdbff, 1'b1);
        // limit change between units of one string
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b0);
        write_limit(LEN_W'(2));
        send_unit(16'h0043, 1'b1);
        write_limit('0);
        send_unit(16'h0041, 1'b1);
        write_limit(LEN_W'(1));
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b1);
        write_limit(LEN_W'(3));
        send_unit(16'h20ac, 1'b1);
        send_pair(21'h1f600, 1'b1);
        write_limit(LEN_W'(4));
        send_pair(21'h1f600, 1'b1);

        // random strings under a sequence of limits
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0, 4:    lim = LIMIT_RESET;
                1:       lim = LEN_W'(1);
                2:       lim = LEN_W'($urandom_range(5, 20));
                3:       lim = LEN_W'($urandom_range(21, 65535));
                5:       lim = LEN_W'(4);
                6:       lim = LEN_W'($urandom_range(2, 12));
                default: lim = LEN_W'(65536);
            endcase
            write_limit(lim);
            quiet = (phase == 3);
            if (phase == 4)
                hold_req = 1'b1;
            target = units_sent + PHASE_UNITS;
            while (units_sent < target)
                send_random_string();
        end
        quiet = 1'b0;

        in_ch.valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/u2u8_pkg.sv
hw/rtl/u2u8_in_if.sv
hw/rtl/u2u8_out_if.sv
hw/rtl/u2u8_decode.sv
hw/rtl/u2u8_emit.sv
hw/rtl/utf16_to_utf8_transcoder_core.sv
bench/u2u8_checker.sv
bench/tb_top.sv
